/* src/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk, except while reset is asserted.
`define BCU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication whose consequent is sampled in the cycle after the antecedent.
`define BCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bcu_pkg.sv */
package bcu_pkg;

  // Default operand width for n and k.
  localparam int COUNT_BITS_DEFAULT = 8;
  // The running value wraps at 32 bits.
  localparam int ACC_W = 32;
  localparam int BITCNT_W = $clog2(ACC_W);

  // Microprogram address width.
  localparam int PC_W = 3;

  // Datapath operations.
  localparam logic [2:0] OP_WAIT  = 3'd0;  // Take a new n and k.
  localparam logic [2:0] OP_CHECK = 3'd1;  // Handle k greater than n and fold k.
  localparam logic [2:0] OP_TEST  = 3'd2;  // Compare the step count with k.
  localparam logic [2:0] OP_MUL   = 3'd3;  // Multiply by n minus i, start the division.
  localparam logic [2:0] OP_DIV   = 3'd4;  // One quotient bit.
  localparam logic [2:0] OP_INCR  = 3'd5;  // Advance the step count.
  localparam logic [2:0] OP_EMIT  = 3'd6;  // Load the output register.

  // Sequencing modes.
  localparam logic [1:0] SEQ_NEXT      = 2'd0;  // Go to the next address.
  localparam logic [1:0] SEQ_JUMP      = 2'd1;  // Go to the target.
  localparam logic [1:0] SEQ_JUMP_IF   = 2'd2;  // Target if the flag is set, else next.
  localparam logic [1:0] SEQ_HOLD_JUMP = 2'd3;  // Target if the flag is set, else stay.

  // Microprogram addresses.
  localparam logic [PC_W-1:0] PC_WAIT  = 3'd0;
  localparam logic [PC_W-1:0] PC_CHECK = 3'd1;
  localparam logic [PC_W-1:0] PC_TEST  = 3'd2;
  localparam logic [PC_W-1:0] PC_MUL   = 3'd3;
  localparam logic [PC_W-1:0] PC_DIV   = 3'd4;
  localparam logic [PC_W-1:0] PC_INCR  = 3'd5;
  localparam logic [PC_W-1:0] PC_EMIT  = 3'd6;

  typedef struct packed {
    logic [2:0]      op;
    logic [1:0]      seq;
    logic [PC_W-1:0] target;
  } ucode_t;

  // The control store.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
    ucode_t w;
    unique case (addr)
      PC_WAIT:  w = '{op: OP_WAIT,  seq: SEQ_HOLD_JUMP, target: PC_CHECK};
      PC_CHECK: w = '{op: OP_CHECK, seq: SEQ_JUMP_IF,   target: PC_EMIT};
      PC_TEST:  w = '{op: OP_TEST,  seq: SEQ_JUMP_IF,   target: PC_EMIT};
      PC_MUL:   w = '{op: OP_MUL,   seq: SEQ_NEXT,      target: PC_WAIT};
      PC_DIV:   w = '{op: OP_DIV,   seq: SEQ_HOLD_JUMP, target: PC_INCR};
      PC_INCR:  w = '{op: OP_INCR,  seq: SEQ_JUMP,      target: PC_TEST};
      PC_EMIT:  w = '{op: OP_EMIT,  seq: SEQ_HOLD_JUMP, target: PC_WAIT};
      default:  w = '{op: OP_INCR,  seq: SEQ_JUMP,      target: PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* src/binomial_coefficient_unit.sv */
// Binomial coefficient unit: C(n,k) by the multiplicative formula, 32-bit wrap.
// The input channel (in_valid, in_ready, in_n_total, in_k_chosen) takes one pair
// per transfer. The result channel (out_valid, out_ready, out_coefficient) gives
// exactly one coefficient per input transfer, in order. When k exceeds n the
// result is 0; otherwise k is folded to min(k, n-k) and for each step i the
// running value is multiplied by n-i (low 32 bits kept) and divided by i+1.
// Control is a seven-word microprogram; a program counter walks it with jumps.
// Each step runs a test, a multiply, a 32-bit restoring division that retires
// one quotient bit per cycle, and an increment. When k exceeds n, the check
// step jumps straight to the emit step. One item is in work at a time; the
// next input is taken once the result sits in the output register, even
// while the receiver has not yet taken it.
// If the receiver stalls, out_valid and out_coefficient hold, and the
// sequencer waits at its emit step with the next result until the register
// frees up. Synchronous active-low reset returns the sequencer to its wait
// step and empties the output register; no other state survives an item.
module binomial_coefficient_unit #(
  parameter int COUNT_BITS = bcu_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COUNT_BITS-1:0]    in_n_total,
  input  logic [COUNT_BITS-1:0]    in_k_chosen,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [bcu_pkg::ACC_W-1:0] out_coefficient
);

  localparam int AW = bcu_pkg::ACC_W;
  localparam int BW = bcu_pkg::BITCNT_W;

  // Sequencer state.
  logic [bcu_pkg::PC_W-1:0] pc_r, pc_nxt;
  bcu_pkg::ucode_t          uw;
  logic                     flag;

  // Datapath registers.
  logic [COUNT_BITS-1:0] n_r, n_nxt;
  logic [COUNT_BITS-1:0] k_r, k_nxt;
  logic [COUNT_BITS-1:0] i_r, i_nxt;
  logic [AW-1:0]         acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [BW-1:0]         bitcnt_r, bitcnt_nxt;

  // Output register.
  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_coef_r, out_coef_nxt;

  // Combinational helpers.
  logic [COUNT_BITS-1:0]    n_minus_k;
  logic [COUNT_BITS-1:0]    n_minus_i;
  logic [AW+COUNT_BITS-1:0] product;
  logic [COUNT_BITS:0]      divisor;
  logic [COUNT_BITS:0]      partial;
  logic                     take;
  logic                     out_free;

  assign uw = bcu_pkg::ucode_rom(pc_r);

  assign n_minus_k = n_r - k_r;
  assign n_minus_i = n_r - i_r;
  assign product   = acc_r * n_minus_i;

  // Restoring division by i+1; the quotient shifts into acc from the bottom while
  // the dividend shifts out of the top. The remainder always stays below i+1.
  assign divisor = {1'b0, i_r} + (COUNT_BITS + 1)'(1);
  assign partial = {rem_r, acc_r[AW-1]};
  assign take    = (partial >= divisor);

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (uw.op == bcu_pkg::OP_WAIT);

  // Condition flag for the current microword.
  always_comb begin
    unique case (uw.op)
      bcu_pkg::OP_WAIT:  flag = in_valid;
      bcu_pkg::OP_CHECK: flag = (k_r > n_r);
      bcu_pkg::OP_TEST:  flag = (i_r == k_r);
      bcu_pkg::OP_DIV:   flag = (bitcnt_r == BW'(AW - 1));
      bcu_pkg::OP_EMIT:  flag = out_free;
      default:           flag = 1'b0;
    endcase
  end

  // Next microprogram address.
  always_comb begin
    case (uw.seq)
      bcu_pkg::SEQ_NEXT:    pc_nxt = pc_r + 1'b1;
      bcu_pkg::SEQ_JUMP:    pc_nxt = uw.target;
      bcu_pkg::SEQ_JUMP_IF: pc_nxt = flag ? uw.target : pc_r + 1'b1;
      default:              pc_nxt = flag ? uw.target : pc_r;
    endcase
  end

  // Datapath actions selected by the microword.
  always_comb begin
    n_nxt         = n_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    acc_nxt       = acc_r;
    rem_nxt       = rem_r;
    bitcnt_nxt    = bitcnt_r;
    out_coef_nxt  = out_coef_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (uw.op)
      bcu_pkg::OP_WAIT: begin
        n_nxt = in_n_total;
        k_nxt = in_k_chosen;
      end
      bcu_pkg::OP_CHECK: begin
        // A k above n gives zero; otherwise use the smaller of k and n-k.
        i_nxt = '0;
        if (k_r > n_r) begin
          acc_nxt = '0;
        end else begin
          acc_nxt = AW'(1);
          if (n_minus_k < k_r) begin
            k_nxt = n_minus_k;
          end
        end
      end
      bcu_pkg::OP_TEST: begin
      end
      bcu_pkg::OP_MUL: begin
        acc_nxt    = product[AW-1:0];
        rem_nxt    = '0;
        bitcnt_nxt = '0;
      end
      bcu_pkg::OP_DIV: begin
        rem_nxt    = take ? COUNT_BITS'(partial - divisor) : partial[COUNT_BITS-1:0];
        acc_nxt    = {acc_r[AW-2:0], take};
        bitcnt_nxt = bitcnt_r + 1'b1;
      end
      bcu_pkg::OP_INCR: begin
        i_nxt = i_r + 1'b1;
      end
      bcu_pkg::OP_EMIT: begin
        if (out_free) begin
          out_coef_nxt  = acc_r;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= bcu_pkg::PC_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    acc_r      <= acc_nxt;
    rem_r      <= rem_nxt;
    bitcnt_r   <= bitcnt_nxt;
    out_coef_r <= out_coef_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = out_coef_r;

endmodule

/* src/bcu_checker.sv */
`include "assert_macros.svh"

module bcu_checker #(
  parameter int COUNT_BITS = bcu_pkg::COUNT_BITS_DEFAULT
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [COUNT_BITS-1:0]     in_n_total,
  input logic [COUNT_BITS-1:0]     in_k_chosen,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bcu_pkg::ACC_W-1:0] out_coefficient
);

  // A stalled result stays offered.
  `BCU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its value.
  `BCU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_coefficient),
                   "result changed while stalled")

  // Only one item is in work: after an input transfer the input side closes.
  `BCU_ASSERT_NEXT(a_in_single, in_valid && in_ready, !in_ready,
                   "input stayed open after a transfer")

  // A new result appears only after the sequencer has left its wait step.
  `BCU_ASSERT(a_emit_busy, $rose(out_valid) |-> $past(!in_ready),
              "result appeared while idle")

  // An input item with an empty subset finishes without entering the loop.
  `BCU_ASSERT(a_k_zero_fast,
              (in_valid && in_ready && (in_k_chosen == '0) && (in_n_total != '0)
               && !out_valid) |-> ##4 out_valid,
              "empty subset was slow")

endmodule

bind binomial_coefficient_unit bcu_checker #(.COUNT_BITS(COUNT_BITS)) u_bcu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_n_total      (in_n_total),
  .in_k_chosen     (in_k_chosen),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_coefficient (out_coefficient)
);
